// ===== rtl/core/psfp_pkg.sv =====
package psfp_pkg;

    typedef enum logic
    {
        FMT_32 = 1'b0,
        FMT_10 = 1'b1
    } frame_fmt_t;

    localparam int QUEUE_DEPTH = 4;

    localparam int POS_W  = 5;
    localparam int BYTE_W = 8;
    localparam int VAL_W  = 16;

    // header and tail bytes
    localparam logic [BYTE_W-1:0] HDR0_32 = 8'h42;
    localparam logic [BYTE_W-1:0] HDR1_32 = 8'h4D;
    localparam logic [BYTE_W-1:0] HDR0_10 = 8'hAA;
    localparam logic [BYTE_W-1:0] HDR1_10 = 8'hC0;
    localparam logic [BYTE_W-1:0] TAIL_10 = 8'hAB;
    localparam logic [BYTE_W-1:0] LOW_BYTE = 8'hFF;

    // both header bytes of the 32-byte frame count towards its sum
    localparam logic [VAL_W-1:0] HDR_SUM_32 = 16'h008F;

    localparam logic [POS_W-1:0] POS_HDR0 = 5'd0;
    localparam logic [POS_W-1:0] POS_HDR1 = 5'd1;
    localparam logic [POS_W-1:0] POS_BODY = 5'd2;

    localparam logic [POS_W-1:0] POS_PM25_HI_32 = 5'd6;
    localparam logic [POS_W-1:0] POS_PM25_LO_32 = 5'd7;
    localparam logic [POS_W-1:0] POS_PM10_HI_32 = 5'd8;
    localparam logic [POS_W-1:0] POS_PM10_LO_32 = 5'd9;
    localparam logic [POS_W-1:0] POS_CHK_32     = 5'd30;
    localparam logic [POS_W-1:0] POS_LAST_32    = 5'd31;

    localparam logic [POS_W-1:0] POS_PM25_LO_10 = 5'd2;
    localparam logic [POS_W-1:0] POS_PM25_HI_10 = 5'd3;
    localparam logic [POS_W-1:0] POS_PM10_LO_10 = 5'd4;
    localparam logic [POS_W-1:0] POS_PM10_HI_10 = 5'd5;
    localparam logic [POS_W-1:0] POS_CHK_10     = 5'd8;
    localparam logic [POS_W-1:0] POS_LAST_10    = 5'd9;

    // one body byte of a frame, tagged by the front end
    typedef struct packed
    {
        frame_fmt_t          fmt;
        logic [POS_W-1:0]    pos;
        logic [BYTE_W-1:0]   data;
    } body_entry_t;

    localparam int ENTRY_W = $bits(body_entry_t);

endpackage

// ===== rtl/core/psfp_front.sv =====
module psfp_front
    import psfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [BYTE_W-1:0]   s_tdata,
    input  logic                q_full,
    output logic                q_push,
    output body_entry_t         q_entry
);

    frame_fmt_t         fmt_reg, fmt_next;
    logic [POS_W-1:0]   pos_reg, pos_next;
    logic [BYTE_W-1:0]  hdr0, hdr1;
    logic [POS_W-1:0]   last_pos;
    logic               accept;

    assign cfg_ready = 1'b1;
    // a format write takes the cycle, so no byte is taken alongside it
    assign s_tready  = ~q_full & ~cfg_valid;
    assign accept    = s_tvalid & s_tready;

    assign hdr0     = (fmt_reg == FMT_10) ? HDR0_10 : HDR0_32;
    assign hdr1     = (fmt_reg == FMT_10) ? HDR1_10 : HDR1_32;
    assign last_pos = (fmt_reg == FMT_10) ? POS_LAST_10 : POS_LAST_32;

    assign q_entry.fmt  = fmt_reg;
    assign q_entry.pos  = pos_reg;
    assign q_entry.data = s_tdata;

    always_comb
    begin
        fmt_next = fmt_reg;
        pos_next = pos_reg;
        q_push   = 1'b0;
        if (cfg_valid)
        begin
            // a format change drops any partial frame
            fmt_next = frame_fmt_t'(cfg_data);
            pos_next = POS_HDR0;
        end
        else if (accept)
        begin
            case (pos_reg)
                POS_HDR0:
                begin
                    if (s_tdata == hdr0)
                    begin
                        pos_next = POS_HDR1;
                    end
                end
                POS_HDR1:
                begin
                    if (s_tdata == hdr1)
                    begin
                        pos_next = POS_BODY;
                    end
                    else if (s_tdata == hdr0)
                    begin
                        pos_next = POS_HDR1;
                    end
                    else
                    begin
                        pos_next = POS_HDR0;
                    end
                end
                default:
                begin
                    q_push   = 1'b1;
                    pos_next = (pos_reg == last_pos) ? POS_HDR0 : pos_reg + 1'b1;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            fmt_reg <= FMT_32;
            pos_reg <= POS_HDR0;
        end
        else
        begin
            fmt_reg <= fmt_next;
            pos_reg <= pos_next;
        end
    end

endmodule

// ===== rtl/core/psfp_fifo.sv =====
module psfp_fifo
    import psfp_pkg::*;
#(
    parameter int Depth = QUEUE_DEPTH,
    parameter int Width = ENTRY_W
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push,
    input  logic [Width-1:0]    wr_data,
    input  logic                pop,
    output logic [Width-1:0]    rd_data,
    output logic                full,
    output logic                empty
);

    localparam int PtrW = $clog2(Depth);
    localparam int CntW = $clog2(Depth + 1);

    logic [Width-1:0]   mem_reg [Depth];
    logic [PtrW-1:0]    wr_ptr_reg, wr_ptr_next;
    logic [PtrW-1:0]    rd_ptr_reg, rd_ptr_next;
    logic [CntW-1:0]    count_reg, count_next;

    assign full    = (count_reg == CntW'(Depth));
    assign empty   = (count_reg == '0);
    assign rd_data = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PtrW'(Depth - 1)) ? '0 : wr_ptr_reg + 1'b1;
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PtrW'(Depth - 1)) ? '0 : rd_ptr_reg + 1'b1;
        end
        if (push && !pop)
        begin
            count_next = count_reg + 1'b1;
        end
        else if (pop && !push)
        begin
            count_next = count_reg - 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

endmodule

// ===== rtl/core/psfp_back.sv =====
module psfp_back
    import psfp_pkg::*;
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                q_empty,
    input  body_entry_t         q_entry,
    output logic                q_pop,
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [2*VAL_W-1:0]  m_tdata,
    output logic                m_tuser
);

    logic [VAL_W-1:0]   sum_reg, sum_next;
    logic [BYTE_W-1:0]  chk_reg, chk_next;
    logic [VAL_W-1:0]   pend25_reg, pend25_next;
    logic [VAL_W-1:0]   pend10_reg, pend10_next;
    logic [VAL_W-1:0]   good25_reg, good25_next;
    logic [VAL_W-1:0]   good10_reg, good10_next;
    logic               out_valid_reg, out_valid_next;
    logic               out_err_reg, out_err_next;
    logic [VAL_W-1:0]   out25_reg, out25_next;
    logic [VAL_W-1:0]   out10_reg, out10_next;

    logic               is_last;
    logic               ok;
    logic [VAL_W-1:0]   sum_base;
    logic [VAL_W-1:0]   sum_add;
    logic [BYTE_W-1:0]  b;
    logic [POS_W-1:0]   p;

    assign b = q_entry.data;
    assign p = q_entry.pos;

    assign is_last = (q_entry.fmt == FMT_10) ? (p == POS_LAST_10) : (p == POS_LAST_32);
    // a closing word needs the output slot, other words go straight through
    assign q_pop   = ~q_empty & (~is_last | ~out_valid_reg | m_tready);

    // first body byte restarts the sum
    assign sum_base = (p != POS_BODY) ? sum_reg :
                      (q_entry.fmt == FMT_32) ? HDR_SUM_32 : '0;
    assign sum_add  = sum_base + {{(VAL_W-BYTE_W){1'b0}}, b};

    always_comb
    begin
        if (q_entry.fmt == FMT_10)
        begin
            ok = (b == TAIL_10) && ((sum_reg[BYTE_W-1:0] & LOW_BYTE) == chk_reg);
        end
        else
        begin
            ok = (sum_reg == {chk_reg, b});
        end
    end

    always_comb
    begin
        sum_next       = sum_reg;
        chk_next       = chk_reg;
        pend25_next    = pend25_reg;
        pend10_next    = pend10_reg;
        good25_next    = good25_reg;
        good10_next    = good10_reg;
        out_valid_next = out_valid_reg & ~m_tready;
        out_err_next   = out_err_reg;
        out25_next     = out25_reg;
        out10_next     = out10_reg;
        if (q_pop)
        begin
            case (q_entry.fmt)
                FMT_32:
                begin
                    if (p < POS_CHK_32)
                    begin
                        sum_next = sum_add;
                    end
                    case (p)
                        POS_PM25_HI_32: pend25_next = {b, {BYTE_W{1'b0}}};
                        POS_PM25_LO_32: pend25_next = {pend25_reg[VAL_W-1:BYTE_W], b};
                        POS_PM10_HI_32: pend10_next = {b, {BYTE_W{1'b0}}};
                        POS_PM10_LO_32: pend10_next = {pend10_reg[VAL_W-1:BYTE_W], b};
                        POS_CHK_32:     chk_next    = b;
                        default:        ;
                    endcase
                end
                FMT_10:
                begin
                    if (p < POS_CHK_10)
                    begin
                        sum_next = sum_add;
                    end
                    case (p)
                        POS_PM25_LO_10: pend25_next = {{BYTE_W{1'b0}}, b};
                        POS_PM25_HI_10: pend25_next = {b, pend25_reg[BYTE_W-1:0]};
                        POS_PM10_LO_10: pend10_next = {{BYTE_W{1'b0}}, b};
                        POS_PM10_HI_10: pend10_next = {b, pend10_reg[BYTE_W-1:0]};
                        POS_CHK_10:     chk_next    = b;
                        default:        ;
                    endcase
                end
                default: ;
            endcase
            if (is_last)
            begin
                sum_next       = '0;
                out_valid_next = 1'b1;
                out_err_next   = ~ok;
                out25_next     = ok ? pend25_reg : good25_reg;
                out10_next     = ok ? pend10_reg : good10_reg;
                if (ok)
                begin
                    good25_next = pend25_reg;
                    good10_next = pend10_reg;
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            sum_reg       <= '0;
            chk_reg       <= '0;
            pend25_reg    <= '0;
            pend10_reg    <= '0;
            good25_reg    <= '0;
            good10_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            sum_reg       <= sum_next;
            chk_reg       <= chk_next;
            pend25_reg    <= pend25_next;
            pend10_reg    <= pend10_next;
            good25_reg    <= good25_next;
            good10_reg    <= good10_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        out_err_reg <= out_err_next;
        out25_reg   <= out25_next;
        out10_reg   <= out10_next;
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {out10_reg, out25_reg};
    assign m_tuser  = out_err_reg;

endmodule

// ===== rtl/core/particle_sensor_frame_parser_unit.sv =====
// serial particulate-sensor frame parser
// s_* takes one received byte per word; m_* gives one word per completed frame:
// the error flag on m_tuser and the last good pm2.5 / pm10 readings on m_tdata.
// cfg_* writes the frame format (0: 32-byte frame, 1: 10-byte frame); write it
// only while no frame is in flight, it drops any partial frame and re-hunts.
// a front stage hunts the two header bytes and tags body bytes with their
// position; a small queue hands them to a back stage that keeps the sum, the
// pending and good readings, and an output register.
// throughput: one byte per cycle while the queue has room, as the back stage adds each popped byte to the sum.
// result path: the frame's last byte is written into the queue, popped by the back
// stage and registered into the output register that drives m_tvalid.
// when m_tready is low the finished result holds; body bytes keep flowing
// until the queue fills, then s_tready drops. header and junk bytes are
// swallowed without using the queue. s_tready is low while cfg_valid is high.
// reset clears the format to 0, the good readings to zero and starts hunting.
module particle_sensor_frame_parser_unit
    import psfp_pkg::*;
#(
    parameter int QueueDepth = QUEUE_DEPTH
)
(
    input  logic                clk,
    input  logic                rst_n,
    input  logic                cfg_valid,
    output logic                cfg_ready,
    input  logic                cfg_data,     // frame_format
    input  logic                s_tvalid,
    output logic                s_tready,
    input  logic [7:0]          s_tdata,      // rx_byte
    output logic                m_tvalid,
    input  logic                m_tready,
    output logic [31:0]         m_tdata,      // pm25_value, pm10_value
    output logic                m_tuser       // frame_error
);

    body_entry_t    push_entry;
    body_entry_t    pop_entry;
    logic           q_push;
    logic           q_pop;
    logic           q_full;
    logic           q_empty;

    psfp_front u_front
    (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .q_full    (q_full),
        .q_push    (q_push),
        .q_entry   (push_entry)
    );

    psfp_fifo #(
        .Depth (QueueDepth),
        .Width (ENTRY_W)
    ) u_fifo
    (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (q_push),
        .wr_data (push_entry),
        .pop     (q_pop),
        .rd_data (pop_entry),
        .full    (q_full),
        .empty   (q_empty)
    );

    psfp_back u_back
    (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_empty  (q_empty),
        .q_entry  (pop_entry),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tuser  (m_tuser)
    );

    a_no_push_full: assert property (@(posedge clk) disable iff (!rst_n)
        q_push |-> !q_full)
        else $error("body word pushed into a full queue");

    a_no_pop_empty: assert property (@(posedge clk) disable iff (!rst_n)
        q_pop |-> !q_empty)
        else $error("queue popped while empty");

    a_queue_flags: assert property (@(posedge clk) disable iff (!rst_n)
        !(q_full && q_empty))
        else $error("queue both full and empty");

    a_result_from_pop: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(m_tvalid) |-> $past(q_pop))
        else $error("result appeared without a queue pop");

endmodule

// ===== tb/particle_sensor_frame_parser_unit_tb.sv =====
module particle_sensor_frame_parser_unit_tb
    import psfp_pkg::*;
;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int FRAME_ITEMS   = 2000;
    localparam int IDLE_LIMIT    = 2000;
    localparam int HOLD_CYCLES   = 300;
    localparam int SETTLE_CYCLES = 6;

    typedef enum logic [2:0]
    {
        SEQ_GOOD,
        SEQ_BAD_SUM,
        SEQ_BAD_TAIL,
        SEQ_JUNK,
        SEQ_HDR_REPEAT,
        SEQ_HDR_BREAK,
        SEQ_TRUNC
    } seq_kind_e;

    typedef struct packed
    {
        logic               err;
        logic [VAL_W-1:0]   pm25;
        logic [VAL_W-1:0]   pm10;
    } frame_report_t;

    typedef struct packed
    {
        frame_fmt_t         fmt;
        seq_kind_e          kind;
        logic [VAL_W-1:0]   pm25;
        logic [VAL_W-1:0]   pm10;
        bit                 typed;
        frame_report_t      want;
    } dir_row_t;

    logic           clk;
    logic           rst_n;
    logic           cfg_valid;
    logic           cfg_ready;
    logic           cfg_data;
    logic           s_tvalid;
    logic           s_tready;
    logic [7:0]     s_tdata;       // rx_byte
    logic           m_tvalid;
    logic           m_tready;
    logic [31:0]    m_tdata;       // pm25_value, pm10_value
    logic           m_tuser;       // frame_error

    // parser state as the block should hold it
    frame_fmt_t         model_fmt = FMT_32;
    logic [POS_W-1:0]   model_pos = '0;
    logic [VAL_W-1:0]   model_sum = '0;
    logic [BYTE_W-1:0]  model_chk = '0;
    logic [VAL_W-1:0]   model_pend25 = '0;
    logic [VAL_W-1:0]   model_pend10 = '0;
    logic [VAL_W-1:0]   model_good25 = '0;
    logic [VAL_W-1:0]   model_good10 = '0;

    frame_report_t      frame_reports_q [$];
    logic [7:0]         seq_bytes [$];
    frame_report_t      typed_report;
    bit                 typed_pending = 1'b0;
    bit                 hold_off_req = 1'b0;
    bit                 gap_enable = 1'b1;
    int                 burst_left = 0;
    int                 frame_bytes = 0;
    int                 mismatches = 0;

    dir_row_t dir_table [20] = '{
        '{FMT_32, SEQ_BAD_SUM,    16'h0000, 16'h0000, 1'b1, '{1'b1, 16'h0000, 16'h0000}},
        '{FMT_32, SEQ_GOOD,       16'hFFFF, 16'h0000, 1'b1, '{1'b0, 16'hFFFF, 16'h0000}},
        '{FMT_32, SEQ_GOOD,       16'h0000, 16'hFFFF, 1'b1, '{1'b0, 16'h0000, 16'hFFFF}},
        '{FMT_32, SEQ_BAD_SUM,    16'h1111, 16'h2222, 1'b1, '{1'b1, 16'h0000, 16'hFFFF}},
        '{FMT_32, SEQ_JUNK,       16'h0000, 16'h0000, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_32, SEQ_HDR_REPEAT, 16'h1234, 16'h5678, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_32, SEQ_HDR_BREAK,  16'h0000, 16'h0000, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_32, SEQ_GOOD,       16'h00FF, 16'hFF00, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_32, SEQ_TRUNC,      16'h3C3C, 16'hC3C3, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_32, SEQ_GOOD,       16'hA5A5, 16'h5A5A, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_10, SEQ_GOOD,       16'hFFFF, 16'hFFFF, 1'b1, '{1'b0, 16'hFFFF, 16'hFFFF}},
        '{FMT_10, SEQ_BAD_TAIL,   16'h0101, 16'h0202, 1'b1, '{1'b1, 16'hFFFF, 16'hFFFF}},
        '{FMT_10, SEQ_BAD_SUM,    16'h0303, 16'h0404, 1'b1, '{1'b1, 16'hFFFF, 16'hFFFF}},
        '{FMT_10, SEQ_GOOD,       16'h0000, 16'h0000, 1'b1, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_10, SEQ_HDR_REPEAT, 16'h8001, 16'h0180, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_10, SEQ_HDR_BREAK,  16'h0000, 16'h0000, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_10, SEQ_JUNK,       16'h0000, 16'h0000, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_10, SEQ_TRUNC,      16'h7777, 16'h8888, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_10, SEQ_GOOD,       16'h1357, 16'h2468, 1'b0, '{1'b0, 16'h0000, 16'h0000}},
        '{FMT_32, SEQ_GOOD,       16'h7FFF, 16'h8000, 1'b0, '{1'b0, 16'h0000, 16'h0000}}
    };

    particle_sensor_frame_parser_unit DUT
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_valid  (cfg_valid),
        .cfg_ready  (cfg_ready),
        .cfg_data   (cfg_data),
        .s_tvalid   (s_tvalid),
        .s_tready   (s_tready),
        .s_tdata    (s_tdata),
        .m_tvalid   (m_tvalid),
        .m_tready   (m_tready),
        .m_tdata    (m_tdata),
        .m_tuser    (m_tuser)
    );

    initial
    begin
        clk = 1'b0;
        forever #1 clk = ~clk;
    end

    // advances the parser by one received byte; returns 1 when a frame closes
    function automatic bit parse_rx_byte(input logic [7:0] b, output frame_report_t rep);
        bit ok;
        bit done;
        ok = 1'b0;
        done = 1'b0;
        rep = '0;
        if (model_fmt == FMT_32)
        begin
            if (model_pos == POS_HDR0)
            begin
                if (b == HDR0_32)
                begin
                    model_sum = 16'(b);
                    model_pos = POS_HDR1;
                end
            end
            else if (model_pos == POS_HDR1)
            begin
                if (b == HDR1_32)
                begin
                    model_sum = 16'(HDR0_32) + 16'(b);
                    model_pos = POS_BODY;
                end
                else if (b == HDR0_32)
                begin
                    model_sum = 16'(b);
                    model_pos = POS_HDR1;
                end
                else
                begin
                    model_sum = '0;
                    model_pos = POS_HDR0;
                end
            end
            else
            begin
                if (model_pos < POS_CHK_32)
                    model_sum = model_sum + 16'(b);
                case (model_pos)
                    POS_PM25_HI_32: model_pend25 = {b, 8'h00};
                    POS_PM25_LO_32: model_pend25 = model_pend25 | 16'(b);
                    POS_PM10_HI_32: model_pend10 = {b, 8'h00};
                    POS_PM10_LO_32: model_pend10 = model_pend10 | 16'(b);
                    POS_CHK_32:     model_chk = b;
                    default: ;
                endcase
                if (model_pos >= POS_LAST_32)
                begin
                    ok = (model_sum == {model_chk, b});
                    done = 1'b1;
                end
                else
                    model_pos = model_pos + 1'b1;
            end
        end
        else
        begin
            if (model_pos == POS_HDR0)
            begin
                if (b == HDR0_10)
                begin
                    model_sum = '0;
                    model_pos = POS_HDR1;
                end
            end
            else if (model_pos == POS_HDR1)
            begin
                if (b == HDR1_10)
                    model_pos = POS_BODY;
                else if (b == HDR0_10)
                    model_pos = POS_HDR1;
                else
                    model_pos = POS_HDR0;
                model_sum = '0;
            end
            else
            begin
                if (model_pos < POS_CHK_10)
                    model_sum = model_sum + 16'(b);
                case (model_pos)
                    POS_PM25_LO_10: model_pend25 = 16'(b);
                    POS_PM25_HI_10: model_pend25 = model_pend25 | {b, 8'h00};
                    POS_PM10_LO_10: model_pend10 = 16'(b);
                    POS_PM10_HI_10: model_pend10 = model_pend10 | {b, 8'h00};
                    POS_CHK_10:     model_chk = b;
                    default: ;
                endcase
                if (model_pos >= POS_LAST_10)
                begin
                    ok = (b == TAIL_10) && ((model_sum[7:0] & LOW_BYTE) == model_chk);
                    done = 1'b1;
                end
                else
                    model_pos = model_pos + 1'b1;
            end
        end
        if (done)
        begin
            if (ok)
            begin
                model_good25 = model_pend25;
                model_good10 = model_pend10;
            end
            model_pos = POS_HDR0;
            model_sum = '0;
            rep = '{err: !ok, pm25: model_good25, pm10: model_good10};
        end
        return done;
    endfunction

    function automatic logic [VAL_W-1:0] rand_reading();
        logic [VAL_W-1:0] v;
        v = 16'($urandom);
        case ($urandom_range(0, 7))
            0: v = '0;
            1: v = '1;
            default: ;
        endcase
        return v;
    endfunction

    // called at a falling edge, returns at the falling edge after the word is taken
    task automatic send_byte(input logic [7:0] b);
        frame_report_t rep;
        if (burst_left == 0)
        begin
            if (gap_enable)
            begin
                s_tvalid = 1'b0;
                repeat ($urandom_range(1, 8)) @(negedge clk);
            end
            burst_left = $urandom_range(1, 40);
        end
        burst_left--;
        s_tvalid = 1'b1;
        s_tdata = b;
        do
            @(posedge clk);
        while (!s_tready);
        if (parse_rx_byte(b, rep))
        begin
            if (typed_pending)
            begin
                frame_reports_q.push_back(typed_report);
                typed_pending = 1'b0;
            end
            else
                frame_reports_q.push_back(rep);
        end
        @(negedge clk);
    endtask

    task automatic wait_results_drained();
        s_tvalid = 1'b0;
        while (frame_reports_q.size() != 0)
            @(posedge clk);
        // header bytes give no result, so let the back stage settle too
        repeat (SETTLE_CYCLES) @(posedge clk);
        @(negedge clk);
    endtask

    task automatic write_format(input frame_fmt_t f);
        cfg_valid = 1'b1;
        cfg_data = f;
        do
            @(posedge clk);
        while (!cfg_ready);
        model_fmt = f;
        model_pos = POS_HDR0;
        model_sum = '0;
        @(negedge clk);
        cfg_valid = 1'b0;
    endtask

    task automatic run_seq(input seq_kind_e kind, input logic [15:0] p25,
                           input logic [15:0] p10);
        logic [7:0]     fr [32];
        logic [7:0]     h0;
        logic [7:0]     h1;
        logic [7:0]     junk;
        logic [15:0]    sum;
        int             len;
        int             idx;
        seq_bytes.delete();
        h0 = (model_fmt == FMT_32) ? HDR0_32 : HDR0_10;
        h1 = (model_fmt == FMT_32) ? HDR1_32 : HDR1_10;
        case (kind)
            SEQ_JUNK:
                repeat ($urandom_range(1, 6)) seq_bytes.push_back(8'($urandom));
            SEQ_HDR_BREAK:
            begin
                junk = 8'($urandom);
                if (junk == h0 || junk == h1)
                    junk = junk ^ 8'h10;
                seq_bytes.push_back(h0);
                seq_bytes.push_back(junk);
            end
            default:
            begin
                if (kind == SEQ_HDR_REPEAT)
                    seq_bytes.push_back(h0);
                fr[0] = h0;
                fr[1] = h1;
                for (int i = 2; i < 32; i++)
                    fr[i] = 8'($urandom);
                sum = '0;
                if (model_fmt == FMT_32)
                begin
                    len = 32;
                    fr[POS_PM25_HI_32] = p25[15:8];
                    fr[POS_PM25_LO_32] = p25[7:0];
                    fr[POS_PM10_HI_32] = p10[15:8];
                    fr[POS_PM10_LO_32] = p10[7:0];
                    for (int i = 0; i < POS_CHK_32; i++)
                        sum = sum + 16'(fr[i]);
                    fr[POS_CHK_32] = sum[15:8];
                    fr[POS_LAST_32] = sum[7:0];
                    idx = $urandom_range(POS_CHK_32, POS_LAST_32);
                end
                else
                begin
                    len = 10;
                    fr[POS_PM25_LO_10] = p25[7:0];
                    fr[POS_PM25_HI_10] = p25[15:8];
                    fr[POS_PM10_LO_10] = p10[7:0];
                    fr[POS_PM10_HI_10] = p10[15:8];
                    for (int i = POS_BODY; i < POS_CHK_10; i++)
                        sum = sum + 16'(fr[i]);
                    fr[POS_CHK_10] = sum[7:0];
                    fr[POS_LAST_10] = TAIL_10;
                    idx = (kind == SEQ_BAD_TAIL) ? POS_LAST_10 : POS_CHK_10;
                end
                if (kind == SEQ_BAD_SUM || kind == SEQ_BAD_TAIL)
                    fr[idx] = fr[idx] ^ 8'($urandom_range(1, 255));
                if (kind == SEQ_TRUNC)
                    len = $urandom_range(2, len - 1);
                for (int i = 0; i < len; i++)
                    seq_bytes.push_back(fr[i]);
            end
        endcase
        if (kind != SEQ_JUNK)
            frame_bytes += seq_bytes.size();
        for (int i = 0; i < seq_bytes.size(); i++)
            send_byte(seq_bytes[i]);
        typed_pending = 1'b0;
    endtask

    initial
    begin
        seq_kind_e  kind;
        int         pick;
        int         iter;
        rst_n = 1'b0;
        cfg_valid = 1'b0;
        cfg_data = 1'b0;
        s_tvalid = 1'b0;
        s_tdata = '0;
        repeat (10) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);
        write_format(FMT_32);

        for (int r = 0; r < $size(dir_table); r++)
        begin
            if (dir_table[r].fmt != model_fmt)
            begin
                wait_results_drained();
                write_format(dir_table[r].fmt);
            end
            typed_pending = dir_table[r].typed;
            typed_report = dir_table[r].want;
            run_seq(dir_table[r].kind, dir_table[r].pm25, dir_table[r].pm10);
        end

        iter = 0;
        while (frame_bytes < FRAME_ITEMS)
        begin
            if (iter % 15 == 14)
            begin
                wait_results_drained();
                write_format(frame_fmt_t'($urandom_range(0, 1)));
                gap_enable = ($urandom_range(0, 3) != 0);
            end
            // long receiver hold while words keep coming, to fill the queue
            if (iter == 30 || iter == 120)
                hold_off_req = 1'b1;
            pick = $urandom_range(0, 99);
            if (pick < 65)
                kind = SEQ_GOOD;
            else if (pick < 75)
                kind = SEQ_BAD_SUM;
            else if (pick < 80)
                kind = SEQ_BAD_TAIL;
            else if (pick < 86)
                kind = SEQ_JUNK;
            else if (pick < 90)
                kind = SEQ_HDR_REPEAT;
            else if (pick < 94)
                kind = SEQ_HDR_BREAK;
            else
                kind = SEQ_TRUNC;
            run_seq(kind, rand_reading(), rand_reading());
            iter++;
        end

        wait_results_drained();
        if (mismatches == 0)
            $display("PASSED: all results match");
        else
            $display("FAILED: results differ");
        $finish;
    end

    // result side back-pressure
    initial
    begin
        int stall_mode;
        int mode_left;
        int cyc;
        stall_mode = 0;
        mode_left = 0;
        cyc = 0;
        m_tready = 1'b0;
        wait (rst_n);
        forever
        begin
            @(negedge clk);
            if (hold_off_req)
            begin
                m_tready = 1'b0;
                repeat (HOLD_CYCLES) @(negedge clk);
                hold_off_req = 1'b0;
            end
            else
            begin
                if (mode_left == 0)
                begin
                    stall_mode = $urandom_range(0, 3);
                    mode_left = $urandom_range(20, 120);
                end
                mode_left--;
                cyc++;
                case (stall_mode)
                    0: m_tready = 1'b1;
                    1: m_tready = 1'($urandom_range(0, 1));
                    2: m_tready = ($urandom_range(0, 3) == 0);
                    default: m_tready = ((cyc % 5) < 3);
                endcase
            end
        end
    end

    always @(posedge clk)
    begin
        frame_report_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (frame_reports_q.size() == 0)
            begin
                $display("%0t: word with nothing expected: err %0b pm25 %h pm10 %h",
                         $time, m_tuser, m_tdata[15:0], m_tdata[31:16]);
                mismatches++;
            end
            else
            begin
                want = frame_reports_q.pop_front();
                if (m_tuser !== want.err)
                begin
                    $display("%0t: frame_error expected %0b got %0b", $time, want.err, m_tuser);
                    mismatches++;
                end
                if (m_tdata[15:0] !== want.pm25)
                begin
                    $display("%0t: pm25_value expected %h got %h",
                             $time, want.pm25, m_tdata[15:0]);
                    mismatches++;
                end
                if (m_tdata[31:16] !== want.pm10)
                begin
                    $display("%0t: pm10_value expected %h got %h",
                             $time, want.pm10, m_tdata[31:16]);
                    mismatches++;
                end
            end
        end
    end

    initial
    begin
        int idle_cycles;
        idle_cycles = 0;
        while (idle_cycles < IDLE_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || (cfg_valid && cfg_ready))
                idle_cycles = 0;
            else
                idle_cycles++;
        end
        $display("%0t: no handshake for %0d cycles", $time, IDLE_LIMIT);
        $display("FAILED: results differ");
        $finish;
    end

endmodule
